>>> rtl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg: shared types and constants for the restricted circular deque
// Holds word widths, request and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rcd_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int WORD_W        = 32;
	localparam int FUNC_W        = 3;
	localparam int STATUS_W      = 2;

	// Request codes carried by the func field.
	typedef enum logic [FUNC_W-1:0] {
		FN_QUERY     = 3'd0,
		FN_INS_RIGHT = 3'd1,
		FN_INS_LEFT  = 3'd2,
		FN_DEL_LEFT  = 3'd3,
		FN_DEL_RIGHT = 3'd4
	} rcd_func_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_OVER   = 2'd1,
		ST_UNDER  = 2'd2,
		ST_DENIED = 2'd3
	} rcd_status_t;

	// Restriction modes.
	localparam logic MODE_IN_RESTRICTED  = 1'b0;
	localparam logic MODE_OUT_RESTRICTED = 1'b1;

	// Datapath operations.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH_R,
		OP_PUSH_L,
		OP_POP_L,
		OP_POP_R
	} rcd_op_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FETCH,
		S_POST
	} rcd_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic        load_item;
		logic        exec;
		rcd_op_t     op;
		rcd_status_t status;
		logic        fetch;
		logic        load_out;
	} rcd_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              mode;
		logic              empty;
		logic              full;
		logic              last;
	} rcd_stat_t;

endpackage

>>> rtl/rcd_channels.sv
// ----------------------------------------------------------------------------
// rcd_channels: handshake channels of the restricted circular deque
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------

// Request channel: one deque request per transfer.
interface rcd_req_if
	import rcd_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

// Response channel: one result per transfer.
interface rcd_rsp_if
	import rcd_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [WORD_W-1:0] removed_value;
	logic signed [WORD_W-1:0] front_value;
	logic signed [WORD_W-1:0] rear_value;
	logic                     is_empty;
	logic                     is_full;

	modport source (output valid, output status, output removed_value, output front_value,
		output rear_value, output is_empty, output is_full, input ready);
	modport sink (input valid, input status, input removed_value, input front_value,
		input rear_value, input is_empty, input is_full, output ready);
endinterface

// Configuration channel: writes the restriction mode register.
interface rcd_cfg_if;
	logic valid;
	logic ready;
	logic restrict_mode;

	modport source (output valid, output restrict_mode, input ready);
	modport sink (input valid, input restrict_mode, output ready);
endinterface

>>> rtl/rcd_ctrl.sv
// ----------------------------------------------------------------------------
// rcd_ctrl: controller of the restricted circular deque
// Sequences each request through execute, optional slot fetch and result
// hand-off, and decides the status and the datapath operation.
// ----------------------------------------------------------------------------
module rcd_ctrl
	import rcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  rcd_stat_t stat,
	output rcd_cmd_t  cmd
);

	rcd_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	// State register and response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign req_ready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		cmd.load_item = 1'b0;
		cmd.exec      = 1'b0;
		cmd.op        = OP_NONE;
		cmd.status    = ST_DONE;
		cmd.fetch     = 1'b0;
		cmd.load_out  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_POST;
				case (stat.func)
					FN_QUERY: begin
						cmd.status = ST_DONE;
					end
					FN_INS_RIGHT, FN_INS_LEFT: begin
						if (stat.func == FN_INS_LEFT && stat.mode == MODE_IN_RESTRICTED) begin
							cmd.status = ST_DENIED;
						end else if (stat.full) begin
							cmd.status = ST_OVER;
						end else begin
							cmd.op = (stat.func == FN_INS_RIGHT) ? OP_PUSH_R : OP_PUSH_L;
						end
					end
					FN_DEL_LEFT, FN_DEL_RIGHT: begin
						if (stat.func == FN_DEL_RIGHT && stat.mode == MODE_OUT_RESTRICTED) begin
							cmd.status = ST_DENIED;
						end else if (stat.empty) begin
							cmd.status = ST_UNDER;
						end else begin
							cmd.op = (stat.func == FN_DEL_LEFT) ? OP_POP_L : OP_POP_R;
							// A new end word must be read unless the deque empties.
							if (!stat.last) begin
								state_d = S_FETCH;
							end
						end
					end
					default: begin
						cmd.status = ST_DENIED;
					end
				endcase
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_POST;
			end
			S_POST: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/rcd_datapath.sv
// ----------------------------------------------------------------------------
// rcd_datapath: datapath of the restricted circular deque
// Slot memory, end indices, shadow copies of the end words, the mode
// register and the response register.
// ----------------------------------------------------------------------------
module rcd_datapath
	import rcd_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_mode,
	input  logic [FUNC_W-1:0]        req_func,
	input  logic signed [WORD_W-1:0] req_value,
	input  rcd_cmd_t                 cmd,
	output rcd_stat_t                stat,
	output logic [STATUS_W-1:0]      rsp_status,
	output logic signed [WORD_W-1:0] rsp_removed,
	output logic signed [WORD_W-1:0] rsp_front,
	output logic signed [WORD_W-1:0] rsp_rear,
	output logic                     rsp_empty,
	output logic                     rsp_full
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	logic [WORD_W-1:0] mem [DEPTH];

	logic                mode_q;
	logic [FUNC_W-1:0]   func_q;
	logic [WORD_W-1:0]   value_q;
	logic [IDX_W-1:0]    front_q, rear_q;
	logic                empty_q;
	logic [WORD_W-1:0]   front_val_q, rear_val_q;
	logic [WORD_W-1:0]   rd_data_q;
	logic                pop_left_q;
	logic [STATUS_W-1:0] status_q;
	logic [WORD_W-1:0]   removed_q;

	logic [IDX_W-1:0]    front_nx, front_pv, rear_nx, rear_pv;
	logic                full;
	logic                we;
	logic [IDX_W-1:0]    wr_addr;
	logic                re;
	logic [IDX_W-1:0]    rd_addr;

	// Circular neighbors of the end indices.
	assign front_nx = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign front_pv = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign rear_nx  = (rear_q == LAST_IDX) ? '0 : rear_q + 1'b1;
	assign rear_pv  = (rear_q == '0) ? LAST_IDX : rear_q - 1'b1;

	assign full = !empty_q && (rear_nx == front_q);

	assign stat.func  = func_q;
	assign stat.mode  = mode_q;
	assign stat.empty = empty_q;
	assign stat.full  = full;
	assign stat.last  = (front_q == rear_q);

	// Memory write and read addresses for the operation in progress.
	always_comb begin
		we      = 1'b0;
		wr_addr = '0;
		re      = 1'b0;
		rd_addr = front_nx;
		if (cmd.exec) begin
			case (cmd.op)
				OP_PUSH_R: begin
					we      = 1'b1;
					wr_addr = empty_q ? '0 : rear_nx;
				end
				OP_PUSH_L: begin
					we      = 1'b1;
					wr_addr = empty_q ? '0 : front_pv;
				end
				OP_POP_L: begin
					re      = 1'b1;
					rd_addr = front_nx;
				end
				OP_POP_R: begin
					re      = 1'b1;
					rd_addr = rear_pv;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	// Slot memory with a registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= value_q;
		end
		if (re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Mode register and deque control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IN_RESTRICTED;
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
			if (cmd.exec) begin
				case (cmd.op)
					OP_PUSH_R, OP_PUSH_L: begin
						if (empty_q) begin
							front_q <= '0;
							rear_q  <= '0;
							empty_q <= 1'b0;
						end else if (cmd.op == OP_PUSH_R) begin
							rear_q <= rear_nx;
						end else begin
							front_q <= front_pv;
						end
					end
					OP_POP_L, OP_POP_R: begin
						if (front_q == rear_q) begin
							front_q <= '0;
							rear_q  <= '0;
							empty_q <= 1'b1;
						end else if (cmd.op == OP_POP_L) begin
							front_q <= front_nx;
						end else begin
							rear_q <= rear_pv;
						end
					end
					default: begin
						empty_q <= empty_q;
					end
				endcase
			end
		end
	end

	// Request capture, end word shadows and per-request results.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q  <= req_func;
			value_q <= req_value;
		end
		if (cmd.exec) begin
			status_q   <= cmd.status;
			pop_left_q <= (cmd.op == OP_POP_L);
			case (cmd.op)
				OP_PUSH_R: begin
					rear_val_q <= value_q;
					removed_q  <= '0;
					if (empty_q) begin
						front_val_q <= value_q;
					end
				end
				OP_PUSH_L: begin
					front_val_q <= value_q;
					removed_q   <= '0;
					if (empty_q) begin
						rear_val_q <= value_q;
					end
				end
				OP_POP_L: begin
					removed_q <= front_val_q;
				end
				OP_POP_R: begin
					removed_q <= rear_val_q;
				end
				default: begin
					removed_q <= '0;
				end
			endcase
		end
		// The word behind the removed end becomes the new end word.
		if (cmd.fetch) begin
			if (pop_left_q) begin
				front_val_q <= rd_data_q;
			end else begin
				rear_val_q <= rd_data_q;
			end
		end
		// Response register.
		if (cmd.load_out) begin
			rsp_status  <= status_q;
			rsp_removed <= removed_q;
			rsp_front   <= empty_q ? '1 : front_val_q;
			rsp_rear    <= empty_q ? '1 : rear_val_q;
			rsp_empty   <= empty_q;
			rsp_full    <= full;
		end
	end

endmodule

>>> rtl/restricted_circular_deque.sv
// ----------------------------------------------------------------------------
// restricted_circular_deque: double-ended queue in a circular slot memory
// Each request runs through the execute and post states, a delete that leaves
// words behind also through fetch (one read of the slot memory through its
// registered port). Requests are taken only in idle, and one is taken while
// the previous response still waits. Reset clears the indices to zero, marks
// the deque empty and sets input-restricted mode; slot contents stay undefined.
// ----------------------------------------------------------------------------
module restricted_circular_deque
	import rcd_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input logic      clk,
	input logic      arst_n,
	rcd_cfg_if.sink  cfg,
	rcd_req_if.sink  req,
	rcd_rsp_if.source rsp
);

	rcd_cmd_t  cmd;
	rcd_stat_t stat;

	// Mode writes must arrive only while idle; the block does not enforce it. They are always taken.
	assign cfg.ready = 1'b1;

	// Sequencing of each request.
	rcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, indices and response register.
	rcd_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_mode    (cfg.restrict_mode),
		.req_func    (req.func),
		.req_value   (req.value),
		.cmd         (cmd),
		.stat        (stat),
		.rsp_status  (rsp.status),
		.rsp_removed (rsp.removed_value),
		.rsp_front   (rsp.front_value),
		.rsp_rear    (rsp.rear_value),
		.rsp_empty   (rsp.is_empty),
		.rsp_full    (rsp.is_full)
	);

endmodule
